/* hdl/lpt_pkg.sv */
// Shared constants and types of the lane point tracker.
`timescale 1ns / 1ps
`default_nettype none

package lpt_pkg;

  localparam int WORD_PIXELS   = 64;
  localparam int IMAGE_COLS    = 768;
  localparam int IMAGE_ROWS    = 512;
  localparam int WORDS_PER_ROW = (IMAGE_COLS + WORD_PIXELS - 1) / WORD_PIXELS;
  localparam int STORE_DEPTH   = IMAGE_ROWS * WORDS_PER_ROW;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);

  localparam int CENTER_COL    = 384;
  localparam int TARGET_LEFT   = 238;
  localparam int TARGET_RIGHT  = 529;
  localparam int FIRST_ROW     = 500;
  localparam int BAND_MAIN     = 448;
  localparam int BAND_ALT      = 320;
  localparam int SPAN_LOW      = 128;
  localparam int SPAN_WIDTH    = 512;
  localparam int TRUST_NEEDED  = 5;

  localparam int CENTER_WORD   = CENTER_COL / WORD_PIXELS;
  localparam int SPAN_WORD_LO  = SPAN_LOW / WORD_PIXELS;
  localparam int SPAN_WORD_HI  = (SPAN_LOW + SPAN_WIDTH) / WORD_PIXELS - 1;

  localparam logic [2:0] REG_POINT_COUNT  = 3'd0;
  localparam logic [2:0] REG_HALF_WIDTH   = 3'd1;
  localparam logic [2:0] REG_ROW_STEP     = 3'd2;
  localparam logic [2:0] REG_SMOOTH_LIMIT = 3'd3;
  localparam logic [2:0] REG_FOLLOW_MODE  = 3'd4;

  localparam logic [1:0] FOLLOW_MID   = 2'd0;
  localparam logic [1:0] FOLLOW_LEFT  = 2'd1;
  localparam logic [1:0] FOLLOW_RIGHT = 2'd2;

  typedef logic [9:0]         col_t;
  typedef logic signed [11:0] pos_t;
  typedef logic signed [5:0]  wd_t;

  typedef struct packed {
    wd_t  wd;
    pos_t lo;
    pos_t hi;
    logic from_high;
  } scan_req_t;

  typedef struct packed {
    logic hit;
    col_t col;
  } scan_res_t;

endpackage

`default_nettype wire

/* hdl/lane_point_tracker.sv */
// Lane point tracker: frame store, start column search, row tracking and result.
//
// A frame of 512 rows by 768 binary pixels arrives on the in_ channel, one
// 64-pixel word per beat in raster order (bit 0 leftmost), with in_tlast on
// the final word. Loading takes one word per cycle. After the final word the
// block stops taking beats and works on the stored frame, which sits in one
// RAM with a write port and a registered read port; all timing comes from
// its reads. The band check reads one word from each of 64 rows, each column
// word of the start search is summed over 64 rows (two to eight words), and
// each sampled row reads zero to five words per edge, followed by setup and
// smoothness checks.
// One result beat then appears on out_: out_tdata holds the offset, out_tuser
// the lane flag. It is held until out_tready; meanwhile the next frame may
// already be loaded, and a new result waits for the old one to be taken.
// Configuration writes on cfg_ are taken at any time but are meant for idle.
// Reset clears the word pointer and the control state and restores register
// defaults; the frame memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module lane_point_tracker
  import lpt_pkg::*;
#(
  parameter int MAX_POINTS = 50
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // pixel_word
  input  wire logic        in_tlast,   // last_word
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata,  // offset_times_five[12:0], zero fill
  output logic             out_tuser,  // lane_found
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int KW = $clog2(MAX_POINTS + 1);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_BAND  = 4'd1;
  localparam logic [3:0] S_COL   = 4'd2;
  localparam logic [3:0] S_COLEV = 4'd3;
  localparam logic [3:0] S_TINIT = 4'd4;
  localparam logic [3:0] S_TRD   = 4'd5;
  localparam logic [3:0] S_TEV   = 4'd6;
  localparam logic [3:0] S_FDIF  = 4'd7;
  localparam logic [3:0] S_SQL   = 4'd8;
  localparam logic [3:0] S_SQR   = 4'd9;
  localparam logic [3:0] S_ACC   = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [8:0] row, input logic [3:0] wd);
    addr_of = ADDR_W'({row, 3'b0}) + ADDR_W'({row, 2'b0}) + ADDR_W'(wd);
  endfunction

  logic [3:0]             state_r;
  logic [ADDR_W-1:0]      wp_r;
  logic [5:0]             pc_r;
  logic [6:0]             shw_r;
  logic [3:0]             step_r;
  logic [15:0]            lim_r;
  logic [1:0]             mode_r;

  logic [6:0]             sweep_r;
  logic                   rv_r;
  logic                   alt_r;
  logic [8:0]             band_r;
  wd_t                    wd_r;
  wd_t                    wd_end_r;
  logic                   side_r;
  logic [3:0]             cnt64_r [WORD_PIXELS];
  col_t                   ls_r;
  col_t                   rs_r;
  pos_t                   lo_r;
  pos_t                   hi_r;
  logic signed [10:0]     row_r;
  logic                   zero_r;
  logic [KW-1:0]          k_r;
  logic                   final_r;
  col_t                   c0l_r, c1l_r, c2l_r, c0r_r, c1r_r, c2r_r;
  logic                   t1l_r, t2l_r, t1r_r, t2r_r;
  logic signed [11:0]     dl_r, dr_r;
  logic                   sm_en_r, okl_r, okr_r;
  logic [2:0]             cnt_r;
  logic [11:0]            sum_r;
  logic                   out_tvalid_r;
  logic signed [12:0]     out_off_r;
  logic                   out_found_r;

  logic                   in_acc;
  logic                   ram_we;
  logic [ADDR_W-1:0]      raddr;
  logic [WORD_PIXELS-1:0] ram_q;
  logic [WORD_PIXELS-1:0] col_hot;
  logic [KW-1:0]          n_pts;
  logic                   sweep_done;
  scan_req_t              scan_req;
  scan_res_t              scan_res;
  logic [WORD_PIXELS-1:0] scan_data;
  pos_t                   base_c;
  pos_t                   t_lo, t_hi, ls_p, rs_p, w_p;
  logic                   rec_go, rec_hit;
  logic signed [11:0]     sq_in;
  logic signed [23:0]     sq;
  logic                   sq_ok;
  logic                   trl, trr, sel_tr;
  col_t                   sel_col, mid;
  logic signed [12:0]     target5;
  logic                   out_free;

  assign in_tready  = (state_r == S_LOAD);
  assign in_acc     = in_tvalid && in_tready;
  assign ram_we     = in_acc && (wp_r < ADDR_W'(STORE_DEPTH));
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b0, out_off_r};
  assign out_tuser  = out_found_r;
  assign out_free   = !out_tvalid_r || out_tready;
  assign sweep_done = sweep_r[6] && !rv_r;
  assign n_pts = ({1'b0, pc_r} > 7'(MAX_POINTS)) ? KW'(MAX_POINTS) : KW'(pc_r);

  always_comb begin
    if (state_r == S_BAND || state_r == S_COL) begin
      raddr = addr_of(band_r + {3'b0, sweep_r[5:0]}, wd_r[3:0]);
    end else begin
      raddr = addr_of(row_r[8:0], wd_r[3:0]);
    end
  end

  lpt_ram #(
    .WIDTH(WORD_PIXELS),
    .DEPTH(STORE_DEPTH)
  ) u_frame (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp_r),
    .wdata(in_tdata[WORD_PIXELS-1:0]),
    .raddr(raddr),
    .rdata(ram_q)
  );

  always_comb begin
    for (int b = 0; b < WORD_PIXELS; b++) begin
      col_hot[b] = cnt64_r[b][3];
    end
    base_c             = {wd_r, 6'b0};
    scan_req.wd        = wd_r;
    scan_req.from_high = !side_r;
    if (state_r == S_COLEV) begin
      scan_req.lo = (!side_r && wd_r == 6'(SPAN_WORD_LO)) ? 12'(SPAN_LOW + 1) : base_c;
      scan_req.hi = base_c + 12'(WORD_PIXELS - 1);
      scan_data   = col_hot;
    end else begin
      scan_req.lo = lo_r;
      scan_req.hi = hi_r;
      scan_data   = zero_r ? '0 : ram_q;
    end
  end

  lpt_word_scan u_scan (
    .data(scan_data),
    .req (scan_req),
    .res (scan_res)
  );

  always_comb begin
    ls_p = $signed({2'b0, ls_r});
    rs_p = $signed({2'b0, rs_r});
    w_p  = $signed({5'b0, shw_r});
    if (!side_r) begin
      t_hi = ls_p + w_p;
      t_lo = ls_p - w_p + 12'sd1;
    end else begin
      t_lo = rs_p - w_p;
      t_hi = rs_p + w_p - 12'sd1;
    end
    rec_hit = (state_r == S_TEV) && scan_res.hit;
    rec_go  = ((state_r == S_TINIT) && (shw_r == '0)) ||
              ((state_r == S_TEV) && (scan_res.hit || wd_r == wd_end_r));
  end

  assign sq_in = (state_r == S_SQL) ? dl_r : dr_r;
  assign sq    = sq_in * sq_in;
  assign sq_ok = $unsigned(sq) < {6'b0, lim_r, 2'b0};

  always_comb begin
    trl = t1l_r && (!sm_en_r || okl_r);
    trr = t1r_r && (!sm_en_r || okr_r);
    mid = 10'(({1'b0, c1l_r} + {1'b0, c1r_r}) >> 1);
    case (mode_r)
      FOLLOW_LEFT: begin
        sel_col = c1l_r;
        sel_tr  = trl;
      end
      FOLLOW_RIGHT: begin
        sel_col = c1r_r;
        sel_tr  = trr;
      end
      default: begin
        sel_col = mid;
        sel_tr  = trl && trr;
      end
    endcase
    case (mode_r)
      FOLLOW_MID:   target5 = 13'(CENTER_COL * TRUST_NEEDED);
      FOLLOW_LEFT:  target5 = 13'(TARGET_LEFT * TRUST_NEEDED);
      FOLLOW_RIGHT: target5 = 13'(TARGET_RIGHT * TRUST_NEEDED);
      default:      target5 = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= 6'd25;
      shw_r  <= 7'd40;
      step_r <= 4'd5;
      lim_r  <= 16'd15;
      mode_r <= FOLLOW_MID;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POINT_COUNT:  pc_r   <= cfg_data[5:0];
        REG_HALF_WIDTH:   shw_r  <= cfg_data[6:0];
        REG_ROW_STEP:     step_r <= cfg_data[3:0];
        REG_SMOOTH_LIMIT: lim_r  <= cfg_data;
        REG_FOLLOW_MODE:  mode_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_BAND || state_r == S_COL) begin
      if (!sweep_r[6]) begin
        sweep_r <= sweep_r + 7'd1;
      end
      rv_r <= !sweep_r[6];
    end
    if (state_r == S_BAND && rv_r && ram_q[0]) begin
      alt_r <= 1'b1;
    end
    if (state_r == S_COL && rv_r) begin
      for (int b = 0; b < WORD_PIXELS; b++) begin
        cnt64_r[b] <= cnt64_r[b] + {3'b0, ram_q[b] & ~cnt64_r[b][3]};
      end
    end

    if (!rst_n) begin
      state_r      <= S_LOAD;
      wp_r         <= '0;
      out_tvalid_r <= 1'b0;
      cnt_r        <= '0;
    end else begin
      if (state_r == S_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
        out_found_r  <= (cnt_r == 3'(TRUST_NEEDED));
        out_off_r    <= (cnt_r == 3'(TRUST_NEEDED)) ? target5 - $signed({1'b0, sum_r}) : '0;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        S_LOAD: begin
          if (ram_we) begin
            wp_r <= wp_r + ADDR_W'(1);
          end
          if (in_acc && in_tlast) begin
            wp_r    <= '0;
            sweep_r <= '0;
            rv_r    <= 1'b0;
            alt_r   <= 1'b0;
            band_r  <= 9'(BAND_MAIN);
            wd_r    <= 6'(CENTER_WORD);
            state_r <= S_BAND;
          end
        end
        S_BAND: begin
          if (sweep_done) begin
            band_r  <= alt_r ? 9'(BAND_ALT) : 9'(BAND_MAIN);
            wd_r    <= 6'(CENTER_WORD);
            side_r  <= 1'b1;
            sweep_r <= '0;
            for (int b = 0; b < WORD_PIXELS; b++) begin
              cnt64_r[b] <= '0;
            end
            state_r <= S_COL;
          end
        end
        S_COL: begin
          if (sweep_done) begin
            state_r <= S_COLEV;
          end
        end
        S_COLEV: begin
          sweep_r <= '0;
          for (int b = 0; b < WORD_PIXELS; b++) begin
            cnt64_r[b] <= '0;
          end
          state_r <= S_COL;
          if (side_r) begin
            if (scan_res.hit || wd_r == 6'(SPAN_WORD_HI)) begin
              rs_r   <= scan_res.hit ? scan_res.col : 10'(SPAN_LOW + SPAN_WIDTH);
              side_r <= 1'b0;
              wd_r   <= 6'(CENTER_WORD - 1);
            end else begin
              wd_r <= wd_r + 6'sd1;
            end
          end else begin
            if (scan_res.hit || wd_r == 6'(SPAN_WORD_LO)) begin
              ls_r    <= scan_res.hit ? scan_res.col : 10'(SPAN_LOW);
              k_r     <= '0;
              row_r   <= 11'(FIRST_ROW);
              final_r <= 1'b0;
              cnt_r   <= '0;
              sum_r   <= '0;
              state_r <= (n_pts == '0) ? S_DONE : S_TINIT;
            end else begin
              wd_r <= wd_r - 6'sd1;
            end
          end
        end
        S_TINIT: begin
          lo_r     <= t_lo;
          hi_r     <= t_hi;
          wd_r     <= side_r ? t_lo[11:6] : t_hi[11:6];
          wd_end_r <= side_r ? t_hi[11:6] : t_lo[11:6];
          state_r  <= S_TRD;
        end
        S_TRD: begin
          zero_r  <= row_r[10] || wd_r[5] || (wd_r > $signed(6'(WORDS_PER_ROW - 1)));
          state_r <= S_TEV;
        end
        S_TEV: begin
          if (!rec_go) begin
            wd_r    <= side_r ? wd_r + 6'sd1 : wd_r - 6'sd1;
            state_r <= S_TRD;
          end
        end
        S_FDIF: begin
          dl_r    <= $signed({2'b0, c0l_r}) + $signed({2'b0, c2l_r}) - $signed({1'b0, c1l_r, 1'b0});
          dr_r    <= $signed({2'b0, c0r_r}) + $signed({2'b0, c2r_r}) - $signed({1'b0, c1r_r, 1'b0});
          sm_en_r <= (k_r >= KW'(2)) && !final_r;
          state_r <= S_SQL;
        end
        S_SQL: begin
          okl_r   <= sq_ok;
          state_r <= S_SQR;
        end
        S_SQR: begin
          okr_r   <= sq_ok;
          state_r <= S_ACC;
        end
        S_ACC: begin
          if ((final_r || k_r != '0) && sel_tr && cnt_r < 3'(TRUST_NEEDED)) begin
            cnt_r <= cnt_r + 3'd1;
            sum_r <= sum_r + {2'b0, sel_col};
          end
          if (final_r) begin
            state_r <= S_DONE;
          end else begin
            c0l_r <= c1l_r;
            c1l_r <= c2l_r;
            t1l_r <= t2l_r;
            c0r_r <= c1r_r;
            c1r_r <= c2r_r;
            t1r_r <= t2r_r;
            if (k_r == n_pts - KW'(1)) begin
              final_r <= 1'b1;
              sm_en_r <= 1'b0;
              state_r <= S_ACC;
            end else begin
              k_r     <= k_r + KW'(1);
              row_r   <= row_r - $signed({7'b0, step_r});
              state_r <= S_TINIT;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase

      if (rec_go) begin
        if (!side_r) begin
          c2l_r <= rec_hit ? scan_res.col : '0;
          t2l_r <= rec_hit;
          if (rec_hit && $signed({2'b0, scan_res.col}) != hi_r) begin
            ls_r <= scan_res.col;
          end
          side_r  <= 1'b1;
          state_r <= S_TINIT;
        end else begin
          c2r_r <= rec_hit ? scan_res.col : '0;
          t2r_r <= rec_hit;
          if (rec_hit && $signed({2'b0, scan_res.col}) != lo_r) begin
            rs_r <= scan_res.col;
          end
          side_r  <= 1'b0;
          state_r <= S_FDIF;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= ADDR_W'(STORE_DEPTH))
    else $error("word pointer beyond frame store");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(TRUST_NEEDED))
    else $error("trusted count beyond five");
  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> (state_r == S_BAND))
    else $error("final beat did not start processing");
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == S_DONE))
    else $error("result beat raised outside the done state");
  a_hit_in_image: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TEV && scan_res.hit) |-> (scan_res.col < 10'(IMAGE_COLS)))
    else $error("tracked column outside the image");
`endif

endmodule

`default_nettype wire

/* hdl/lpt_ram.sv */
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none

module lpt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 6144
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/lpt_word_scan.sv */
// Finds the first set bit of one word inside a column window, from either end.
`timescale 1ns / 1ps
`default_nettype none

module lpt_word_scan
  import lpt_pkg::*;
(
  input  wire logic [WORD_PIXELS-1:0] data,
  input  wire scan_req_t              req,
  output scan_res_t                   res
);

  pos_t                   base;
  pos_t                   lo_off;
  pos_t                   hi_off;
  logic [WORD_PIXELS-1:0] mask;
  logic [5:0]             pos;

  always_comb begin
    base   = {req.wd, 6'b0};
    lo_off = req.lo - base;
    hi_off = req.hi - base;
    for (int b = 0; b < WORD_PIXELS; b++) begin
      mask[b] = data[b] && ($signed(12'(b)) >= lo_off) && ($signed(12'(b)) <= hi_off);
    end
    pos = '0;
    if (req.from_high) begin
      for (int b = 0; b < WORD_PIXELS; b++) begin
        if (mask[b]) begin
          pos = 6'(b);
        end
      end
    end else begin
      for (int b = WORD_PIXELS - 1; b >= 0; b--) begin
        if (mask[b]) begin
          pos = 6'(b);
        end
      end
    end
    res.hit = |mask;
    res.col = 10'(base + $signed({6'b0, pos}));
  end

endmodule

`default_nettype wire

/* sim/lpt_frame_checker.sv */
// Frame checker: mirrors the frame memory, predicts each lane result and compares it.
`timescale 1ns / 1ps

module lpt_frame_checker
  import lpt_pkg::*;
#(
  parameter int MAX_POINTS = 50
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        out_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          pending,
  output int          errors
);

  typedef struct {
    logic [15:0] offset;
    logic        found;
  } lane_result_t;

  logic [63:0] pixel_mem [0:STORE_DEPTH-1];
  int          load_ptr;
  lane_result_t expected_results [$];

  logic [5:0]  point_count;
  logic [6:0]  half_width;
  logic [3:0]  row_step;
  logic [15:0] smooth_limit;
  logic [1:0]  follow_mode;

  assign pending = expected_results.size();

  initial begin
    errors = 0;
    for (int i = 0; i < STORE_DEPTH; i++) pixel_mem[i] = '0;
  end

  function automatic bit pixel_set(int r, int c);
    if (r < 0 || r >= IMAGE_ROWS || c < 0 || c >= IMAGE_COLS) return 1'b0;
    return pixel_mem[r * WORDS_PER_ROW + c / WORD_PIXELS][c % WORD_PIXELS];
  endfunction

  function automatic bit column_hot(int band, int c);
    int n;
    n = 0;
    for (int k = 0; k < 64; k++) n += pixel_set(band + k, c);
    return n * 255 > 2000;
  endfunction

  function automatic lane_result_t predict_lane();
    lane_result_t res;
    int n, w, stp, band, c, ls, rs, rr, i, target, cnt, total, off;
    int lcol [MAX_POINTS];
    int rcol [MAX_POINTS];
    bit ltr [MAX_POINTS];
    bit rtr [MAX_POINTS];
    int fcol [MAX_POINTS];
    bit ftr [MAX_POINTS];
    longint d;
    n = (point_count > MAX_POINTS) ? MAX_POINTS : point_count;
    w = half_width;
    stp = row_step;
    band = BAND_MAIN;
    for (int k = 0; k < 64; k++)
      if (pixel_set(BAND_MAIN + k, CENTER_COL)) band = BAND_ALT;
    for (c = SPAN_WIDTH / 2; c < SPAN_WIDTH; c++)
      if (column_hot(band, c + SPAN_LOW)) break;
    rs = c + SPAN_LOW;
    for (c = SPAN_WIDTH / 2 - 1; c > 0; c--)
      if (column_hot(band, c + SPAN_LOW)) break;
    ls = c + SPAN_LOW;
    for (int k = 0; k < MAX_POINTS; k++) begin
      lcol[k] = 0; rcol[k] = 0; ltr[k] = 0; rtr[k] = 0;
    end
    for (int k = 0; k < n; k++) begin
      rr = FIRST_ROW - k * stp;
      for (i = ls + w; i > ls - w; i--) begin
        if (pixel_set(rr, i)) begin
          lcol[k] = i; ltr[k] = 1;
          if (i != ls + w) ls = i;
          break;
        end
      end
      for (i = rs - w; i < rs + w; i++) begin
        if (pixel_set(rr, i)) begin
          rcol[k] = i; rtr[k] = 1;
          if (i != rs - w) rs = i;
          break;
        end
      end
    end
    for (int k = 1; k < n - 1; k++) begin
      d = lcol[k-1] + lcol[k+1] - 2 * lcol[k];
      ltr[k] = ltr[k] && (d * d < 4 * longint'(smooth_limit));
      d = rcol[k-1] + rcol[k+1] - 2 * rcol[k];
      rtr[k] = rtr[k] && (d * d < 4 * longint'(smooth_limit));
    end
    for (int k = 0; k < MAX_POINTS; k++) begin
      case (follow_mode)
        FOLLOW_LEFT: begin
          fcol[k] = lcol[k]; ftr[k] = ltr[k];
        end
        FOLLOW_RIGHT: begin
          fcol[k] = rcol[k]; ftr[k] = rtr[k];
        end
        default: begin
          fcol[k] = (lcol[k] + rcol[k]) / 2; ftr[k] = ltr[k] && rtr[k];
        end
      endcase
    end
    case (follow_mode)
      FOLLOW_MID:   target = CENTER_COL;
      FOLLOW_LEFT:  target = TARGET_LEFT;
      FOLLOW_RIGHT: target = TARGET_RIGHT;
      default:      target = 0;
    endcase
    cnt = 0;
    total = 0;
    for (int k = 0; k < n && cnt < TRUST_NEEDED; k++) begin
      if (ftr[k]) begin
        cnt++;
        total += fcol[k];
      end
    end
    if (cnt >= TRUST_NEEDED) begin
      off = target * TRUST_NEEDED - total;
      res.offset = {3'b000, off[12:0]};
      res.found = 1'b1;
    end else begin
      res.offset = '0;
      res.found = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      load_ptr <= 0;
      point_count <= 6'd25;
      half_width <= 7'd40;
      row_step <= 4'd5;
      smooth_limit <= 16'd15;
      follow_mode <= FOLLOW_MID;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_POINT_COUNT:  point_count <= cfg_data[5:0];
          REG_HALF_WIDTH:   half_width <= cfg_data[6:0];
          REG_ROW_STEP:     row_step <= cfg_data[3:0];
          REG_SMOOTH_LIMIT: smooth_limit <= cfg_data;
          REG_FOLLOW_MODE:  follow_mode <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (load_ptr < STORE_DEPTH) pixel_mem[load_ptr] = in_tdata;
        if (in_tlast) begin
          load_ptr <= 0;
          expected_results.push_back(predict_lane());
        end else if (load_ptr < STORE_DEPTH) begin
          load_ptr <= load_ptr + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    lane_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: offset %0h lane_found %0b", out_tdata, out_tuser);
        errors++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_tdata !== exp_res.offset) begin
          $error("offset_times_five: expected %0h actual %0h", exp_res.offset, out_tdata);
          errors++;
        end
        if (out_tuser !== exp_res.found) begin
          $error("lane_found: expected %0b actual %0b", exp_res.found, out_tuser);
          errors++;
        end
      end
    end
  end

endmodule

/* sim/tb_lane_point_tracker.sv */
// Testbench top: frame stimulus, idle patterns, configuration phases and verdict.
`timescale 1ns / 1ps

module tb_lane_point_tracker;
  import lpt_pkg::*;

  typedef struct {
    int lbase;
    int rbase;
    int lslope;
    int rslope;
    int width;
    int noise;
    int dash;
    bit blob;
    bit dense;
  } lane_image_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // pixel_word
  logic        in_tlast;   // last_word
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // offset_times_five[12:0], zero fill
  logic        out_tuser;  // lane_found
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  int          pending;
  int          errors;
  int          burst_left;
  int          hold_request;
  int          hold_done;
  lane_image_t img;

  lane_point_tracker uut (.*);

  lpt_frame_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    out_tready <= 1'b0;
    hold_done = 0;
    @(posedge clk);
    forever begin
      if (hold_request != hold_done) begin
        out_tready <= 1'b0;
        repeat (10000) @(posedge clk);
        hold_done++;
      end else begin
        case ($urandom_range(0, 3))
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= 1'b0;
          default: out_tready <= $urandom_range(0, 1);
        endcase
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  function automatic bit lane_pixel(int r, int c);
    int lc, rc;
    if (img.dash > 0 && ((r / img.dash) % 2) == 1) return 1'b0;
    lc = img.lbase + ((500 - r) * img.lslope) / 64;
    rc = img.rbase + ((500 - r) * img.rslope) / 64;
    if ((c - lc < img.width && lc - c < img.width) ||
        (c - rc < img.width && rc - c < img.width)) return 1'b1;
    if (img.blob && r >= BAND_MAIN && c >= 380 && c <= 388) return 1'b1;
    return $urandom_range(0, 999) < img.noise;
  endfunction

  function automatic logic [63:0] image_word(int idx);
    logic [63:0] wd;
    int r, c0;
    if (img.dense) return {$urandom, $urandom};
    r = idx / WORDS_PER_ROW;
    c0 = (idx % WORDS_PER_ROW) * WORD_PIXELS;
    for (int b = 0; b < 64; b++) wd[b] = lane_pixel(r, c0 + b);
    return wd;
  endfunction

  task automatic random_image();
    img.lbase = $urandom_range(140, 370);
    img.rbase = $urandom_range(390, 630);
    img.lslope = int'($urandom_range(0, 40)) - 20;
    img.rslope = int'($urandom_range(0, 40)) - 20;
    img.width = $urandom_range(1, 6);
    img.noise = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 20);
    img.dash = ($urandom_range(0, 2) == 0) ? $urandom_range(4, 40) : 0;
    img.blob = ($urandom_range(0, 4) == 0);
    img.dense = ($urandom_range(0, 7) == 0);
  endtask

  task automatic send_word(input logic [63:0] wd, input logic last);
    int gap;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 8);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(500, 3000)
                                               : $urandom_range(1, 64);
    end
    in_tvalid <= 1'b1;
    in_tdata <= wd;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_frame(input int nwords);
    for (int i = 0; i < nwords; i++) send_word(image_word(i), i == nwords - 1);
    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_config(input int pc, input int hw, input int st, input int lim,
                              input int fm);
    while (pending != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_POINT_COUNT;  cfg_data <= 16'(pc);  @(posedge clk);
    cfg_index <= REG_HALF_WIDTH;   cfg_data <= 16'(hw);  @(posedge clk);
    cfg_index <= REG_ROW_STEP;     cfg_data <= 16'(st);  @(posedge clk);
    cfg_index <= REG_SMOOTH_LIMIT; cfg_data <= 16'(lim); @(posedge clk);
    cfg_index <= REG_FOLLOW_MODE;  cfg_data <= 16'(fm);  @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int nframes;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tlast <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_POINT_COUNT;
    cfg_data <= '0;
    burst_left = 0;
    hold_request = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The first frame fills the whole memory and runs past its end; a pixel on
    // the center column in the lower band moves the start search up.
    img = '{200, 560, 8, -8, 2, 5, 0, 1'b1, 1'b0};
    send_frame(STORE_DEPTH + 7);
    img = '{250, 520, 0, 0, 3, 0, 0, 1'b0, 1'b0};
    send_frame(20);
    write_config(50, 127, 10, 65535, FOLLOW_LEFT);
    send_frame(1);
    write_config(63, 1, 1, 0, FOLLOW_RIGHT);
    send_frame(24);
    write_config(3, 0, 0, 15, 3);
    send_frame(12);
    img = '{0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1};
    write_config(5, 40, 15, 1000, FOLLOW_MID);
    send_frame(30);

    for (int ph = 0; ph < 40; ph++) begin
      if ($urandom_range(0, 3) == 0)
        write_config($urandom_range(0, 1) ? 3 : 63, $urandom_range(0, 1) ? 0 : 127,
                     $urandom_range(0, 1) ? 0 : 15, $urandom_range(0, 1) ? 0 : 65535,
                     $urandom_range(0, 3));
      else
        write_config($urandom_range(3, 50), $urandom_range(1, 127), $urandom_range(1, 10),
                     ($urandom_range(0, 1) ? $urandom_range(0, 100) : $urandom_range(0, 65535)),
                     $urandom_range(0, 2));
      nframes = $urandom_range(1, 2);
      if (ph == 20) begin
        hold_request++;
        nframes = 3;
      end
      for (int f = 0; f < nframes; f++) begin
        random_image();
        send_frame($urandom_range(1, 20));
      end
    end

    while (pending != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* lane_point_tracker.f */
hdl/lpt_pkg.sv
hdl/lpt_ram.sv
hdl/lpt_word_scan.sv
hdl/lane_point_tracker.sv
sim/lpt_frame_checker.sv
sim/tb_lane_point_tracker.sv
